// ===== rtl/wsc_pkg.sv =====
// Shared constants, register codes and handshake structs for the wheel speed tachometer.
// Used by wsc_ratio and wheel_speed_from_capture; no dependencies.
`timescale 1ns / 1ps

package wsc_pkg;

	localparam int RING_DEPTH = 16;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int ENTRY_W    = 17;
	localparam int SUM_W      = ENTRY_W + RING_AW;
	localparam int PD_W       = 24;
	localparam int NUM_W      = PD_W + CNT_W;
	localparam int STEP_W     = $clog2(NUM_W);

	localparam int TIME_W     = 32;
	localparam int MIN_W      = 16;
	localparam int GAP_W      = 17;
	localparam int WIN_W      = 20;
	localparam int TMO_W      = 8;
	localparam int SIL_W      = 8;
	localparam int SPEED_W    = 16;
	localparam int COUNT_W    = 5;

	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int COUNT_LIMIT = (RING_DEPTH < COUNT_MAX) ? RING_DEPTH : COUNT_MAX;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [MIN_W-1:0] MIN_INTERVAL_RST  = MIN_W'(300);
	localparam logic [GAP_W-1:0] RESTART_GAP_RST   = GAP_W'(100000);
	localparam logic [WIN_W-1:0] WINDOW_SUM_RST    = WIN_W'(10000);
	localparam logic [TMO_W-1:0] TIMEOUT_RST       = TMO_W'(26);
	localparam logic [PD_W-1:0]  PULSE_DIST_RST    = PD_W'(4984250);

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_GAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SUM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_DIST   = 3'd4;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} ratio_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [SPEED_W-1:0] speed;
	} ratio_rsp_t;

endpackage

// ===== rtl/wheel_speed_from_capture.sv =====
// Top level of the period-averaging wheel tachometer: control, interval ring, config registers.
// Depends on wsc_pkg and wsc_ratio.
`timescale 1ns / 1ps

// Each input beat is either a wheel edge carrying a 32-bit microsecond timestamp or a
// one-millisecond tick, and each yields exactly one result beat with the current speed in
// mm/s and the number of intervals averaged. Items are handled one at a time. A tick, a
// glitch edge or a restart edge goes from the check state to the output state, and an
// edge that stores a zero interval passes the walk state first. A normal edge walks k
// ring entries (1 to 16, one per cycle), then the bit-serial multiplier and the
// restoring divider run in turn, one quotient bit a cycle. Input ready returns the cycle
// after the result register loads; a finished result waits in the output state while the
// output register holds an unread beat. The result register decouples the output: the
// next item is taken while a result still waits. Configuration writes (cfg_ready is
// always high) must only be issued while no item is in flight.
module wheel_speed_from_capture (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [wsc_pkg::TIME_W-1:0]        capture_time_us,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wsc_pkg::SPEED_W-1:0]       speed_mm_s,
	output logic [wsc_pkg::COUNT_W-1:0]       intervals_used,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_WALK  = 5'b00100,
		S_CALC  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                               state_q;

	logic [wsc_pkg::MIN_W-1:0]            min_interval_q;
	logic [wsc_pkg::GAP_W-1:0]            restart_gap_q;
	logic [wsc_pkg::WIN_W-1:0]            window_sum_q;
	logic [wsc_pkg::TMO_W-1:0]            timeout_q;
	logic [wsc_pkg::PD_W-1:0]             pulse_dist_q;

	logic                                 op_q;
	logic [wsc_pkg::TIME_W-1:0]           stamp_q;
	logic [wsc_pkg::TIME_W-1:0]           prev_stamp_q;
	logic [wsc_pkg::ENTRY_W-1:0]          ring_q [wsc_pkg::RING_DEPTH];
	logic [wsc_pkg::RING_DEPTH-1:0]       ring_vld_q;
	logic [wsc_pkg::RING_AW-1:0]          wp_q;
	logic [wsc_pkg::RING_AW-1:0]          pos_q;
	logic [wsc_pkg::CNT_W-1:0]            cnt_q;
	logic [wsc_pkg::SUM_W-1:0]            sum_q;
	logic [wsc_pkg::SPEED_W-1:0]          speed_q;
	logic [wsc_pkg::COUNT_W-1:0]          count_q;
	logic [wsc_pkg::SIL_W-1:0]            silence_q;

	logic                                 out_valid_q;
	logic [wsc_pkg::SPEED_W-1:0]          speed_out_q;
	logic [wsc_pkg::COUNT_W-1:0]          count_out_q;

	logic [wsc_pkg::TIME_W-1:0]           delta;
	logic                                 is_glitch;
	logic                                 is_restart;
	logic [wsc_pkg::SIL_W-1:0]            sil_inc;
	logic [wsc_pkg::ENTRY_W-1:0]          entry;
	logic                                 entry_zero;
	logic [wsc_pkg::SUM_W-1:0]            sum_nx;
	logic [wsc_pkg::CNT_W-1:0]            cnt_nx;
	logic                                 walk_end;
	logic [wsc_pkg::CNT_W-1:0]            fin_cnt;
	logic [wsc_pkg::SUM_W-1:0]            fin_sum;
	logic [wsc_pkg::COUNT_W-1:0]          cnt_sat;
	logic [wsc_pkg::RING_AW-1:0]          wp_nx;
	logic [wsc_pkg::RING_AW-1:0]          pos_nx;
	logic                                 out_load;

	wsc_pkg::ratio_req_t                  ratio_req;
	wsc_pkg::ratio_rsp_t                  ratio_rsp;

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= wsc_pkg::MIN_INTERVAL_RST;
			restart_gap_q  <= wsc_pkg::RESTART_GAP_RST;
			window_sum_q   <= wsc_pkg::WINDOW_SUM_RST;
			timeout_q      <= wsc_pkg::TIMEOUT_RST;
			pulse_dist_q   <= wsc_pkg::PULSE_DIST_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wsc_pkg::REG_MIN_INTERVAL: min_interval_q <= cfg_data[wsc_pkg::MIN_W-1:0];
				wsc_pkg::REG_RESTART_GAP:  restart_gap_q  <= cfg_data[wsc_pkg::GAP_W-1:0];
				wsc_pkg::REG_WINDOW_SUM:   window_sum_q   <= cfg_data[wsc_pkg::WIN_W-1:0];
				wsc_pkg::REG_TIMEOUT:      timeout_q      <= cfg_data[wsc_pkg::TMO_W-1:0];
				wsc_pkg::REG_PULSE_DIST:   pulse_dist_q   <= cfg_data[wsc_pkg::PD_W-1:0];
				default: ;
			endcase
		end
	end

	// edge classification
	assign delta      = stamp_q - prev_stamp_q;
	assign is_glitch  = delta < 32'(min_interval_q);
	assign is_restart = delta > 32'(restart_gap_q);
	assign sil_inc    = (silence_q == '1) ? silence_q : silence_q + wsc_pkg::SIL_W'(1);
	assign wp_nx      = (wp_q == wsc_pkg::RING_AW'(wsc_pkg::RING_DEPTH - 1)) ? '0
		: wp_q + wsc_pkg::RING_AW'(1);

	// backward walk, one entry a cycle; an entry cleared by restart reads as zero
	assign entry      = ring_vld_q[pos_q] ? ring_q[pos_q] : '0;
	assign entry_zero = entry == '0;
	assign sum_nx     = sum_q + wsc_pkg::SUM_W'(entry);
	assign cnt_nx     = cnt_q + wsc_pkg::CNT_W'(1);
	assign pos_nx     = (pos_q == '0) ? wsc_pkg::RING_AW'(wsc_pkg::RING_DEPTH - 1)
		: pos_q - wsc_pkg::RING_AW'(1);
	assign walk_end   = entry_zero || !((32'(sum_nx) < 32'(window_sum_q))
		&& (cnt_nx < wsc_pkg::CNT_W'(wsc_pkg::RING_DEPTH)));
	assign fin_cnt    = entry_zero ? cnt_q : cnt_nx;
	assign fin_sum    = entry_zero ? sum_q : sum_nx;
	assign cnt_sat    = (32'(fin_cnt) > wsc_pkg::COUNT_MAX) ? wsc_pkg::COUNT_W'(wsc_pkg::COUNT_MAX)
		: wsc_pkg::COUNT_W'(fin_cnt);

	assign ratio_req.start = (state_q == S_WALK) && walk_end && (fin_cnt != '0);
	assign ratio_req.count = fin_cnt;
	assign ratio_req.sum   = fin_sum;

	wsc_ratio u_ratio (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (ratio_req),
		.pulse_distance_nm (pulse_dist_q),
		.rsp               (ratio_rsp)
	);

	assign in_ready = state_q == S_IDLE;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_stamp_q <= '0;
			ring_vld_q   <= '0;
			wp_q         <= '0;
			speed_q      <= '0;
			count_q      <= '0;
			silence_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_OUT;
					if (op_q == wsc_pkg::OP_TICK) begin
						silence_q <= sil_inc;
						if (sil_inc > timeout_q) begin
							speed_q <= '0;
							count_q <= '0;
						end
					end else begin
						silence_q <= '0;
						if (!is_glitch) begin
							prev_stamp_q <= stamp_q;
							if (is_restart) begin
								ring_vld_q <= '0;
								wp_q       <= '0;
							end else begin
								ring_vld_q[wp_q] <= 1'b1;
								wp_q             <= wp_nx;
								state_q          <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (walk_end) begin
						if (fin_cnt == '0) begin
							// zero-length interval: nothing to average
							speed_q <= '0;
							count_q <= '0;
							state_q <= S_OUT;
						end else begin
							count_q <= cnt_sat;
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					if (ratio_rsp.done) begin
						speed_q <= ratio_rsp.speed;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= operation;
			stamp_q <= capture_time_us;
		end
		if (state_q == S_CHECK) begin
			ring_q[wp_q] <= delta[wsc_pkg::ENTRY_W-1:0];
			pos_q        <= wp_q;
			cnt_q        <= '0;
			sum_q        <= '0;
		end else if (state_q == S_WALK) begin
			pos_q <= pos_nx;
			cnt_q <= cnt_nx;
			sum_q <= sum_nx;
		end
		if (out_load) begin
			speed_out_q <= speed_q;
			count_out_q <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign speed_mm_s     = speed_out_q;
	assign intervals_used = count_out_q;

	// new items only enter while the serial ratio unit is free
	a_ready_ratio_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ratio_rsp.busy)
		else $error("input ready while ratio unit busy");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_rsp.done |-> state_q == S_CALC)
		else $error("ratio result outside calc state");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(intervals_used) <= wsc_pkg::COUNT_LIMIT)
		else $error("intervals_used beyond ring depth");

	a_zero_count_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && intervals_used == '0) |-> speed_mm_s == '0)
		else $error("speed without any averaged interval");

endmodule

// ===== rtl/wsc_ratio.sv =====
// Bit-serial speed ratio: shift-add multiply of distance by count, then restoring divide by sum.
// Depends on wsc_pkg.
`timescale 1ns / 1ps

module wsc_ratio (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wsc_pkg::ratio_req_t          req,
	input  logic [wsc_pkg::PD_W-1:0]     pulse_distance_nm,
	output wsc_pkg::ratio_rsp_t          rsp
);

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_MUL  = 3'b010,
		R_DIV  = 3'b100
	} phase_t;

	phase_t                              phase_q;
	logic [wsc_pkg::STEP_W-1:0]          step_q;
	logic [wsc_pkg::CNT_W-1:0]           mlt_q;
	logic [wsc_pkg::NUM_W-1:0]           num_q;
	logic [wsc_pkg::SUM_W-1:0]           div_q;
	logic [wsc_pkg::SUM_W-1:0]           rem_q;
	logic                                done_q;
	logic [wsc_pkg::SPEED_W-1:0]         speed_q;

	logic [wsc_pkg::NUM_W-1:0]           mul_nx;
	logic [wsc_pkg::SUM_W:0]             rem_sh;
	logic                                ge;
	logic [wsc_pkg::SUM_W-1:0]           rem_nx;
	logic [wsc_pkg::NUM_W-1:0]           quo_nx;

	// multiply: MSB-first over the count bits
	assign mul_nx = {num_q[wsc_pkg::NUM_W-2:0], 1'b0}
		+ (mlt_q[wsc_pkg::CNT_W-1] ? wsc_pkg::NUM_W'(pulse_distance_nm) : '0);

	// divide: quotient bits shift into num_q as dividend bits shift out
	assign rem_sh = {rem_q, num_q[wsc_pkg::NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? wsc_pkg::SUM_W'(rem_sh - {1'b0, div_q}) : rem_sh[wsc_pkg::SUM_W-1:0];
	assign quo_nx = {num_q[wsc_pkg::NUM_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= R_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				R_IDLE: begin
					if (req.start) begin
						phase_q <= R_MUL;
						step_q  <= wsc_pkg::STEP_W'(wsc_pkg::CNT_W - 1);
					end
				end
				R_MUL: begin
					if (step_q == '0) begin
						phase_q <= R_DIV;
						step_q  <= wsc_pkg::STEP_W'(wsc_pkg::NUM_W - 1);
					end else begin
						step_q <= step_q - wsc_pkg::STEP_W'(1);
					end
				end
				R_DIV: begin
					if (step_q == '0) begin
						phase_q <= R_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q - wsc_pkg::STEP_W'(1);
					end
				end
				default: phase_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			R_IDLE: begin
				if (req.start) begin
					mlt_q <= req.count;
					div_q <= req.sum;
					num_q <= '0;
					rem_q <= '0;
				end
			end
			R_MUL: begin
				num_q <= mul_nx;
				mlt_q <= {mlt_q[wsc_pkg::CNT_W-2:0], 1'b0};
			end
			R_DIV: begin
				num_q <= quo_nx;
				rem_q <= rem_nx;
				if (step_q == '0) begin
					speed_q <= (|quo_nx[wsc_pkg::NUM_W-1:wsc_pkg::SPEED_W]) ? '1
						: quo_nx[wsc_pkg::SPEED_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign rsp.busy  = phase_q != R_IDLE;
	assign rsp.done  = done_q;
	assign rsp.speed = speed_q;

endmodule

// ===== tb/wheel_speed_from_capture_test.sv =====
// Self-checking bench for the wheel tachometer: directed and random edge/tick beats, with a
// cycle-free speed predictor, register sweeps and back-pressure. Depends on wsc_pkg and the RTL.
`timescale 1ns / 1ps

module wheel_speed_from_capture_test;

	typedef struct packed {
		logic [wsc_pkg::SPEED_W-1:0] speed;
		logic [wsc_pkg::COUNT_W-1:0] count;
	} speed_beat_t;

	localparam int SPEED_SAT    = (1 << wsc_pkg::SPEED_W) - 1;
	localparam int SILENCE_SAT  = (1 << wsc_pkg::SIL_W) - 1;
	localparam int DRAIN_CYCLES = 64;

	logic                           clk             = 1'b0;
	logic                           arst_n          = 1'b0;
	logic                           in_valid        = 1'b0;
	logic                           in_ready;
	logic                           operation       = wsc_pkg::OP_TICK;
	logic [wsc_pkg::TIME_W-1:0]     capture_time_us = '0;
	logic                           out_valid;
	logic                           out_ready       = 1'b0;
	logic [wsc_pkg::SPEED_W-1:0]    speed_mm_s;
	logic [wsc_pkg::COUNT_W-1:0]    intervals_used;
	logic                           cfg_valid       = 1'b0;
	logic                           cfg_ready;
	logic [wsc_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [wsc_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

	// predictor copy of the registers and state
	logic [wsc_pkg::MIN_W-1:0]   min_interval = wsc_pkg::MIN_INTERVAL_RST;
	logic [wsc_pkg::GAP_W-1:0]   restart_gap  = wsc_pkg::RESTART_GAP_RST;
	logic [wsc_pkg::WIN_W-1:0]   window_sum   = wsc_pkg::WINDOW_SUM_RST;
	logic [wsc_pkg::TMO_W-1:0]   timeout_lim  = wsc_pkg::TIMEOUT_RST;
	logic [wsc_pkg::PD_W-1:0]    pulse_nm     = wsc_pkg::PULSE_DIST_RST;
	logic [wsc_pkg::ENTRY_W-1:0] ring_entry [wsc_pkg::RING_DEPTH];
	logic [wsc_pkg::RING_AW-1:0] ring_wr      = '0;
	logic [wsc_pkg::TIME_W-1:0]  prev_stamp   = '0;
	logic [wsc_pkg::SPEED_W-1:0] speed_now    = '0;
	logic [wsc_pkg::COUNT_W-1:0] count_now    = '0;
	logic [wsc_pkg::SIL_W-1:0]   silence_ms   = '0;

	speed_beat_t speed_expected[$];
	int          failures        = 0;
	bit          steady          = 1'b0;
	int          hold_off_cycles = 0;

	wheel_speed_from_capture dut (.*);

	always #4 clk = ~clk;

	function automatic speed_beat_t predict_speed(input logic op,
			input logic [wsc_pkg::TIME_W-1:0] stamp);
		speed_beat_t                beat;
		logic [wsc_pkg::TIME_W-1:0] delta;
		logic [31:0]                sum;
		logic [63:0]                quot;
		int unsigned                pos, cnt;
		bit                         walking;
		if (op == wsc_pkg::OP_TICK) begin
			if (silence_ms < SILENCE_SAT)
				silence_ms++;
			if (silence_ms > timeout_lim) begin
				speed_now = '0;
				count_now = '0;
			end
		end else begin
			delta = stamp - prev_stamp;
			silence_ms = '0;
			// a glitch only restarts the silence count
			if (delta >= min_interval) begin
				prev_stamp = stamp;
				if (delta > restart_gap) begin
					foreach (ring_entry[i])
						ring_entry[i] = '0;
					ring_wr = '0;
				end else begin
					ring_entry[ring_wr] = delta[wsc_pkg::ENTRY_W-1:0];
					pos = ring_wr;
					cnt = 0;
					sum = '0;
					walking = 1'b1;
					// newest first, stop on an empty slot or a full window
					for (int k = 0; k < wsc_pkg::RING_DEPTH; k++) begin
						if (walking && ring_entry[pos] == '0)
							walking = 1'b0;
						if (walking) begin
							sum += ring_entry[pos];
							pos = (pos == 0) ? wsc_pkg::RING_DEPTH - 1 : pos - 1;
							cnt++;
							if (sum >= window_sum)
								walking = 1'b0;
						end
					end
					ring_wr = (ring_wr == wsc_pkg::RING_DEPTH - 1) ? '0 : ring_wr + 1'b1;
					if (cnt == 0) begin
						speed_now = '0;
						count_now = '0;
					end else begin
						quot = (64'(pulse_nm) * cnt) / sum;
						speed_now = (quot > SPEED_SAT) ? wsc_pkg::SPEED_W'(SPEED_SAT)
							: quot[wsc_pkg::SPEED_W-1:0];
						count_now = (cnt > wsc_pkg::COUNT_MAX)
							? wsc_pkg::COUNT_W'(wsc_pkg::COUNT_MAX) : wsc_pkg::COUNT_W'(cnt);
					end
				end
			end
		end
		beat.speed = speed_now;
		beat.count = count_now;
		return beat;
	endfunction

	// result side: ready pattern, long hold-off on request, and the beat checker
	always @(posedge clk) begin
		speed_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (speed_expected.size() == 0) begin
				$error("unexpected result beat: speed_mm_s %0d, intervals_used %0d",
					speed_mm_s, intervals_used);
				failures++;
			end else begin
				want = speed_expected.pop_front();
				if (speed_mm_s !== want.speed) begin
					$error("speed_mm_s: expected %0d, actual %0d", want.speed, speed_mm_s);
					failures++;
				end
				if (intervals_used !== want.count) begin
					$error("intervals_used: expected %0d, actual %0d", want.count,
						intervals_used);
					failures++;
				end
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	task automatic send_item(input logic op, input logic [wsc_pkg::TIME_W-1:0] stamp);
		while (!steady && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		capture_time_us <= stamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		speed_expected.push_back(predict_speed(op, stamp));
	endtask

	task automatic send_edge(input logic [wsc_pkg::TIME_W-1:0] delta);
		send_item(wsc_pkg::OP_EDGE, prev_stamp + delta);
	endtask

	task automatic send_tick();
		send_item(wsc_pkg::OP_TICK, $urandom);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (speed_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [wsc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			wsc_pkg::REG_MIN_INTERVAL: min_interval = data[wsc_pkg::MIN_W-1:0];
			wsc_pkg::REG_RESTART_GAP:  restart_gap  = data[wsc_pkg::GAP_W-1:0];
			wsc_pkg::REG_WINDOW_SUM:   window_sum   = data[wsc_pkg::WIN_W-1:0];
			wsc_pkg::REG_TIMEOUT:      timeout_lim  = data[wsc_pkg::TMO_W-1:0];
			wsc_pkg::REG_PULSE_DIST:   pulse_nm     = data[wsc_pkg::PD_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned min_v, input int unsigned gap_v,
			input int unsigned win_v, input int unsigned tmo_v, input int unsigned pd_v);
		wait_results();
		write_reg(wsc_pkg::REG_MIN_INTERVAL, wsc_pkg::CFG_DATA_W'(min_v));
		write_reg(wsc_pkg::REG_RESTART_GAP, wsc_pkg::CFG_DATA_W'(gap_v));
		write_reg(wsc_pkg::REG_WINDOW_SUM, wsc_pkg::CFG_DATA_W'(win_v));
		write_reg(wsc_pkg::REG_TIMEOUT, wsc_pkg::CFG_DATA_W'(tmo_v));
		write_reg(wsc_pkg::REG_PULSE_DIST, wsc_pkg::CFG_DATA_W'(pd_v));
	endtask

	task automatic test_reset_directed();
		send_item(wsc_pkg::OP_TICK, '1);
		send_item(wsc_pkg::OP_EDGE, 32'd0);          // zero interval below the minimum
		send_item(wsc_pkg::OP_EDGE, 32'd1000);
		send_item(wsc_pkg::OP_EDGE, 32'd2000);
		send_item(wsc_pkg::OP_EDGE, 32'd2299);       // one short of the minimum
		send_item(wsc_pkg::OP_EDGE, 32'd2300);       // exactly the minimum
		send_item(wsc_pkg::OP_EDGE, 32'd7300);       // walk runs into empty slots
		send_item(wsc_pkg::OP_EDGE, 32'd12300);      // walk stops on the window
		send_item(wsc_pkg::OP_EDGE, 32'd112301);     // one past the restart gap
		send_item(wsc_pkg::OP_EDGE, 32'd212301);     // exactly the restart gap
		send_item(wsc_pkg::OP_EDGE, 32'hFFFF_FFFF);
		send_item(wsc_pkg::OP_EDGE, 32'h0000_01FF);  // interval across the timer wrap
		send_item(wsc_pkg::OP_EDGE, 32'h0000_05FF);
		send_item(wsc_pkg::OP_TICK, 32'h0);
		send_item(wsc_pkg::OP_TICK, 32'hAAAA_5555);
		send_item(wsc_pkg::OP_EDGE, 32'h0000_09FF);
		wait_results();
	endtask

	task automatic test_register_extremes();
		wait_results();
		// all-ones data checks the per-register masking
		write_reg(wsc_pkg::REG_MIN_INTERVAL, '1);
		write_reg(wsc_pkg::REG_RESTART_GAP, '1);
		write_reg(wsc_pkg::REG_WINDOW_SUM, '1);
		write_reg(wsc_pkg::REG_TIMEOUT, '1);
		write_reg(wsc_pkg::REG_PULSE_DIST, '1);
		send_edge(32'd65534);
		send_edge(32'd65535);
		send_edge(32'd131071);
		send_edge(32'd131072);
		send_edge(32'd70000);

		configure(1, 1, 1, 0, 0);
		send_edge(32'd1);
		send_edge(32'd2);
		send_edge(32'd1);
		send_edge(32'd0);
		send_tick();

		// short intervals with the largest distance saturate the speed
		configure(1, 131071, 1048575, 255, 16777215);
		repeat (20) send_edge($urandom_range(1, 400));
		repeat (20) send_edge($urandom_range(30000, 65000));

		// a zero interval stored with no minimum gives an empty average
		configure(0, 131071, 10000, 26, 4984250);
		send_edge(32'd0);
		send_edge(32'd500);
		send_edge(32'd0);
		send_edge(32'd700);

		wait_results();
		for (int i = wsc_pkg::REG_PULSE_DIST + 1; i < (1 << wsc_pkg::CFG_IDX_W); i++)
			write_reg(wsc_pkg::CFG_IDX_W'(i), wsc_pkg::CFG_DATA_W'($urandom));
		repeat (4) send_edge($urandom_range(1, 3000));
		wait_results();
	endtask

	task automatic test_silence_timeout();
		configure(wsc_pkg::MIN_INTERVAL_RST, wsc_pkg::RESTART_GAP_RST, wsc_pkg::WINDOW_SUM_RST,
			wsc_pkg::TIMEOUT_RST, wsc_pkg::PULSE_DIST_RST);
		send_edge(32'd1000);
		send_edge(32'd1000);
		repeat (wsc_pkg::TIMEOUT_RST + 1) send_tick();
		send_edge(32'd1000);

		// largest timeout never fires; the counter sits at its ceiling
		configure(wsc_pkg::MIN_INTERVAL_RST, wsc_pkg::RESTART_GAP_RST, wsc_pkg::WINDOW_SUM_RST,
			255, wsc_pkg::PULSE_DIST_RST);
		send_edge(32'd1000);
		repeat (300) send_tick();
		configure(wsc_pkg::MIN_INTERVAL_RST, wsc_pkg::RESTART_GAP_RST, wsc_pkg::WINDOW_SUM_RST,
			254, wsc_pkg::PULSE_DIST_RST);
		send_tick();

		configure(wsc_pkg::MIN_INTERVAL_RST, wsc_pkg::RESTART_GAP_RST, wsc_pkg::WINDOW_SUM_RST,
			0, wsc_pkg::PULSE_DIST_RST);
		send_edge(32'd1000);
		send_tick();
		send_edge(32'd1000);
		wait_results();
	endtask

	task automatic test_result_backpressure();
		configure(wsc_pkg::MIN_INTERVAL_RST, wsc_pkg::RESTART_GAP_RST, wsc_pkg::WINDOW_SUM_RST,
			wsc_pkg::TIMEOUT_RST, wsc_pkg::PULSE_DIST_RST);
		hold_off_cycles = 400;
		repeat (12) begin
			if ($urandom_range(3) == 0)
				send_tick();
			else
				send_edge($urandom_range(300, 4000));
		end
		wait_results();
		// one beat at a time, fully drained in between
		repeat (6) begin
			send_edge($urandom_range(300, 4000));
			wait_results();
		end
	endtask

	task automatic test_random_traffic(input int item_goal);
		int          sent, phase, pick, burst, in_phase;
		int unsigned lo, hi, min_v, gap_v, win_v;
		sent = 0;
		phase = 0;
		while (sent < item_goal) begin
			min_v = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 1500);
			gap_v = ($urandom_range(3) == 0) ? 131071 : $urandom_range(min_v + 1000, 131071);
			case ($urandom_range(3))
				0: win_v = 1;
				1: win_v = 1048575;
				default: win_v = $urandom_range(500, 60000);
			endcase
			configure(min_v, gap_v, win_v,
				($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
				($urandom_range(5) == 0) ? 16777215 : $urandom_range(0, 16777215));
			steady = (phase == 2);
			lo = min_v;
			hi = lo + (($urandom_range(1) == 0) ? win_v / 4 + 100 : gap_v);
			if (hi > gap_v)
				hi = gap_v;
			in_phase = 0;
			while (in_phase < item_goal / 6 && sent < item_goal) begin
				pick = $urandom_range(99);
				burst = 1;
				if (pick < 60)
					send_edge($urandom_range(lo, hi));
				else if (pick < 70)
					send_edge((min_v > 0) ? $urandom_range(0, min_v - 1) : $urandom_range(lo, hi));
				else if (pick < 74)
					send_edge(gap_v + 1 + $urandom_range(0, 1 << 20));
				else if (pick < 76)
					send_item(wsc_pkg::OP_EDGE, $urandom);
				else if (pick < 96)
					send_tick();
				else begin
					burst = $urandom_range(2, 45);
					repeat (burst) send_tick();
				end
				sent += burst;
				in_phase += burst;
			end
			phase++;
		end
		wait_results();
		steady = 1'b0;
	endtask

	initial begin
		#8_000_000;
		$display("wheel_speed_from_capture regression: fail");
		$finish;
	end

	initial begin
		foreach (ring_entry[i])
			ring_entry[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_directed();
		test_register_extremes();
		test_silence_timeout();
		test_result_backpressure();
		test_random_traffic(1400);

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && speed_expected.size() == 0)
			$display("wheel_speed_from_capture regression: pass");
		else
			$display("wheel_speed_from_capture regression: fail");
		$finish;
	end

endmodule
